FILE: hw/rtl/frps_pkg.sv
package frps_pkg;

   localparam int unsigned ForceWidth   = 16;
   localparam int unsigned TicksWidth   = 16;
   localparam int unsigned SlopeWidth   = 16;
   localparam int unsigned HoldWidth    = 32;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned SlewShift    = 10;
   localparam int unsigned ProdWidth    = SlopeWidth + TicksWidth;
   localparam int unsigned SlewWidth    = ProdWidth - SlewShift;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_FWD0 = 3'd1,
      PH_REV0 = 3'd2,
      PH_REV1 = 3'd3,
      PH_FWD1 = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      RM_IDLE = 2'd0,
      RM_RAMP = 2'd1,
      RM_HOLD = 2'd2
   } ramp_mode_type;

   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [CsrIdxWidth-1:0] CSR_TARGET_HIGH = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_TARGET_LOW  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_SLOPE_RATE  = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_HOLD_TIMEOUT = 2'd3;

   typedef struct packed {
      logic                  op;
      logic [ForceWidth-1:0] start_force;
      logic [TicksWidth-1:0] delta_ticks;
   } req_item_type;

   typedef struct packed {
      logic                  active;
      logic [ForceWidth-1:0] drive_force;
      logic                  direction_valid;
      logic                  direction_forward;
      logic                  sequence_done;
      logic                  start_rejected;
   } rsp_item_type;

endpackage

FILE: hw/rtl/frps_in_reg.sv
module frps_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  frps_pkg::req_item_type req_item,
   input  logic                  out_ready,
   output logic                  req_stall,
   output logic                  fire,
   output frps_pkg::req_item_type item_ff
);

   logic                  valid_ff;
   logic                  valid_in;
   logic                  load;
   frps_pkg::req_item_type item_in;

   // The held item moves on whenever the result register can take it.
   assign fire      = valid_ff && out_ready;
   assign req_stall = valid_ff && !out_ready;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !out_ready);
   assign item_in   = load ? req_item : item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

FILE: hw/rtl/frps_engine.sv
module frps_engine (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [frps_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [frps_pkg::CsrDataWidth-1:0]      csr_data,
   input  logic                                   fire,
   input  frps_pkg::req_item_type                 item,
   output frps_pkg::rsp_item_type                 result
);

   logic [frps_pkg::ForceWidth-1:0] target_high_ff;
   logic [frps_pkg::ForceWidth-1:0] target_low_ff;
   logic [frps_pkg::SlopeWidth-1:0] slope_rate_ff;
   logic [frps_pkg::HoldWidth-1:0]  hold_timeout_ff;

   frps_pkg::phase_type             phase_ff, phase_in;
   frps_pkg::ramp_mode_type         ramp_mode_ff, ramp_mode_in;
   logic                            aim_high_ff, aim_high_in;
   logic [frps_pkg::ForceWidth-1:0] force_ff, force_in;
   logic [frps_pkg::HoldWidth-1:0]  hold_elapsed_ff, hold_elapsed_in;
   logic                            first_tick_ff, first_tick_in;

   logic [frps_pkg::TicksWidth-1:0] dt;
   logic [frps_pkg::ProdWidth-1:0]  product;
   logic [frps_pkg::SlewWidth-1:0]  slew;
   logic [frps_pkg::ForceWidth-1:0] target;
   logic [frps_pkg::ForceWidth-1:0] gap;
   logic [frps_pkg::HoldWidth:0]    hold_sum;
   logic [frps_pkg::HoldWidth-1:0]  hold_sat;
   logic                            finished;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_high_ff  <= '0;
         target_low_ff   <= '0;
         slope_rate_ff   <= '0;
         hold_timeout_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            frps_pkg::CSR_TARGET_HIGH:
               target_high_ff <= csr_data[frps_pkg::ForceWidth-1:0];
            frps_pkg::CSR_TARGET_LOW:
               target_low_ff <= csr_data[frps_pkg::ForceWidth-1:0];
            frps_pkg::CSR_SLOPE_RATE:
               slope_rate_ff <= csr_data[frps_pkg::SlopeWidth-1:0];
            frps_pkg::CSR_HOLD_TIMEOUT:
               hold_timeout_ff <= csr_data[frps_pkg::HoldWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= frps_pkg::PH_IDLE;
         ramp_mode_ff    <= frps_pkg::RM_IDLE;
         aim_high_ff     <= 1'b0;
         force_ff        <= '0;
         hold_elapsed_ff <= '0;
         first_tick_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         ramp_mode_ff    <= ramp_mode_in;
         aim_high_ff     <= aim_high_in;
         force_ff        <= force_in;
         hold_elapsed_ff <= hold_elapsed_in;
         first_tick_ff   <= first_tick_in;
      end
   end

   // The slew is only needed on a tick, where the first tick after a start
   // counts as no elapsed time.
   assign dt       = first_tick_ff ? '0 : item.delta_ticks;
   assign product  = {{frps_pkg::TicksWidth{1'b0}}, slope_rate_ff}
                     * {{frps_pkg::SlopeWidth{1'b0}}, dt};
   assign slew     = product[frps_pkg::ProdWidth-1:frps_pkg::SlewShift];
   assign target   = aim_high_ff ? target_high_ff : target_low_ff;
   assign gap      = (target < force_ff) ? (force_ff - target) : (target - force_ff);
   assign hold_sum = {1'b0, hold_elapsed_ff}
                     + {{(frps_pkg::HoldWidth + 1 - frps_pkg::TicksWidth){1'b0}}, dt};
   assign hold_sat = hold_sum[frps_pkg::HoldWidth] ? '1
                                                   : hold_sum[frps_pkg::HoldWidth-1:0];

   always_comb begin
      phase_in        = phase_ff;
      ramp_mode_in    = ramp_mode_ff;
      aim_high_in     = aim_high_ff;
      force_in        = force_ff;
      hold_elapsed_in = hold_elapsed_ff;
      first_tick_in   = first_tick_ff;
      finished        = 1'b0;
      result          = '0;

      if (item.op == frps_pkg::OP_START) begin
         if (phase_ff != frps_pkg::PH_IDLE) begin
            result.start_rejected = 1'b1;
         end else begin
            force_in        = item.start_force;
            phase_in        = frps_pkg::PH_FWD0;
            ramp_mode_in    = frps_pkg::RM_RAMP;
            aim_high_in     = 1'b0;
            hold_elapsed_in = '0;
            first_tick_in   = 1'b1;
         end
      end else if (phase_ff != frps_pkg::PH_IDLE) begin
         first_tick_in = 1'b0;
         case (ramp_mode_ff)
            frps_pkg::RM_RAMP: begin
               // A slew at least as large as the gap lands on the target, so
               // the narrowed slew below never overshoots or wraps.
               if (target != force_ff) begin
                  if ({{(frps_pkg::SlewWidth - frps_pkg::ForceWidth){1'b0}}, gap} <= slew)
                  begin
                     force_in = target;
                  end else if (target < force_ff) begin
                     force_in = force_ff - slew[frps_pkg::ForceWidth-1:0];
                  end else begin
                     force_in = force_ff + slew[frps_pkg::ForceWidth-1:0];
                  end
               end
               if (force_in == target) begin
                  ramp_mode_in    = frps_pkg::RM_HOLD;
                  hold_elapsed_in = '0;
               end
            end
            frps_pkg::RM_HOLD: begin
               hold_elapsed_in = hold_sat;
               if (hold_sat > hold_timeout_ff) begin
                  ramp_mode_in = frps_pkg::RM_IDLE;
                  finished     = 1'b1;
               end
            end
            default: ;
         endcase

         if (finished) begin
            unique case (phase_ff)
               frps_pkg::PH_FWD0: begin
                  result.direction_valid   = 1'b1;
                  result.direction_forward = 1'b0;
                  ramp_mode_in             = frps_pkg::RM_RAMP;
                  phase_in                 = frps_pkg::PH_REV0;
                  aim_high_in              = 1'b1;
               end
               frps_pkg::PH_REV0: begin
                  ramp_mode_in = frps_pkg::RM_RAMP;
                  phase_in     = frps_pkg::PH_REV1;
                  aim_high_in  = 1'b0;
               end
               frps_pkg::PH_REV1: begin
                  result.direction_valid   = 1'b1;
                  result.direction_forward = 1'b1;
                  ramp_mode_in             = frps_pkg::RM_RAMP;
                  phase_in                 = frps_pkg::PH_FWD1;
                  aim_high_in              = 1'b1;
               end
               default: begin
                  result.sequence_done = 1'b1;
                  phase_in             = frps_pkg::PH_IDLE;
               end
            endcase
         end

         result.active      = 1'b1;
         result.drive_force = force_in;
      end
   end

endmodule

FILE: hw/rtl/frps_out_reg.sv
module frps_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  frps_pkg::rsp_item_type result,
   input  logic                   rsp_stall,
   output logic                   out_ready,
   output logic                   rsp_valid,
   output frps_pkg::rsp_item_type rsp_item_ff
);

   logic                   valid_ff;
   logic                   valid_in;
   frps_pkg::rsp_item_type rsp_item_in;

   assign out_ready   = !valid_ff || !rsp_stall;
   assign valid_in    = fire || (valid_ff && rsp_stall);
   assign rsp_item_in = fire ? result : rsp_item_ff;
   assign rsp_valid   = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

endmodule

FILE: hw/rtl/force_ramp_pull_sequencer_core.sv
// An accepted item is held in the input register, then passes through the
// update logic into the result register.
// Throughput: one item per cycle unless a stalled result holds the output;
// the state update and slew multiply are combinational between the registers.
// Reset (synchronous, active high) empties both registers, returns the
// sequencer to idle and clears all configuration registers to zero.
module force_ramp_pull_sequencer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic [frps_pkg::ForceWidth-1:0]     req_start_force,
   input  logic [frps_pkg::TicksWidth-1:0]     req_delta_ticks,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_active,
   output logic [frps_pkg::ForceWidth-1:0]     rsp_drive_force,
   output logic                                rsp_direction_valid,
   output logic                                rsp_direction_forward,
   output logic                                rsp_sequence_done,
   output logic                                rsp_start_rejected,
   input  logic                                csr_write,
   input  logic [frps_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [frps_pkg::CsrDataWidth-1:0]   csr_data
);

   frps_pkg::req_item_type req_item;
   frps_pkg::req_item_type item_ff;
   frps_pkg::rsp_item_type result;
   frps_pkg::rsp_item_type rsp_item_ff;
   logic                   fire;
   logic                   out_ready;

   assign req_item.op          = req_op;
   assign req_item.start_force = req_start_force;
   assign req_item.delta_ticks = req_delta_ticks;

   frps_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .out_ready (out_ready),
      .req_stall (req_stall),
      .fire      (fire),
      .item_ff   (item_ff)
   );

   frps_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .fire      (fire),
      .item      (item_ff),
      .result    (result)
   );

   frps_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .result      (result),
      .rsp_stall   (rsp_stall),
      .out_ready   (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_item_ff (rsp_item_ff)
   );

   assign rsp_active            = rsp_item_ff.active;
   assign rsp_drive_force       = rsp_item_ff.drive_force;
   assign rsp_direction_valid   = rsp_item_ff.direction_valid;
   assign rsp_direction_forward = rsp_item_ff.direction_forward;
   assign rsp_sequence_done     = rsp_item_ff.sequence_done;
   assign rsp_start_rejected    = rsp_item_ff.start_rejected;

endmodule

FILE: hw/rtl/frps_checker.sv
module frps_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_active,
   input logic [frps_pkg::ForceWidth-1:0] rsp_drive_force,
   input logic                            rsp_direction_valid,
   input logic                            rsp_sequence_done,
   input logic                            rsp_start_rejected
);

   // A stalled result must not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive_force))
      else $error("stalled result changed");

   // A result that appears on an empty output comes from an item that was accepted.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && !reset, 2))
      else $error("result appeared without a matching item");

   // An inactive result carries no force and no phase events.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_active |->
         rsp_drive_force == '0 && !rsp_direction_valid && !rsp_sequence_done)
      else $error("inactive result carries activity");

   // A rejected start never runs the sequence, and completion gives no direction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_start_rejected || rsp_sequence_done) |->
         !(rsp_start_rejected && rsp_active) && !rsp_direction_valid)
      else $error("rejected or final result has inconsistent flags");

endmodule

bind force_ramp_pull_sequencer_core frps_checker u_frps_checker (.*);

FILE: tb/sv/force_ramp_pull_sequencer_core_tb.sv
`timescale 1ns / 1ps

module force_ramp_pull_sequencer_core_tb;

   localparam int unsigned IdleLimit = 2000;
   localparam int unsigned Latency   = 2;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic                              req_op = frps_pkg::OP_TICK;
   logic [frps_pkg::ForceWidth-1:0]   req_start_force = '0;
   logic [frps_pkg::TicksWidth-1:0]   req_delta_ticks = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic                              rsp_active;
   logic [frps_pkg::ForceWidth-1:0]   rsp_drive_force;
   logic                              rsp_direction_valid;
   logic                              rsp_direction_forward;
   logic                              rsp_sequence_done;
   logic                              rsp_start_rejected;
   logic                              csr_write = 1'b0;
   logic [frps_pkg::CsrIdxWidth-1:0]  csr_index = '0;
   logic [frps_pkg::CsrDataWidth-1:0] csr_data = '0;

   // Shadow copy of the configuration and of the sequencer state.
   logic [frps_pkg::ForceWidth-1:0] cfg_high_force = '0;
   logic [frps_pkg::ForceWidth-1:0] cfg_low_force = '0;
   logic [frps_pkg::SlopeWidth-1:0] cfg_slope = '0;
   logic [frps_pkg::HoldWidth-1:0]  cfg_hold_timeout = '0;
   frps_pkg::phase_type             seq_phase = frps_pkg::PH_IDLE;
   frps_pkg::ramp_mode_type         seq_mode = frps_pkg::RM_IDLE;
   logic                            seq_aim_high = 1'b0;
   logic [frps_pkg::ForceWidth-1:0] seq_force = '0;
   logic [frps_pkg::HoldWidth-1:0]  seq_hold = '0;
   logic                            seq_first_pending = 1'b0;

   frps_pkg::rsp_item_type pending_drive_rsps[$];
   int unsigned  error_count = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_stall_pct = 0;
   int unsigned  quiet_cycles = 0;
   int unsigned  items_sent = 0;

   force_ramp_pull_sequencer_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_op                (req_op),
      .req_start_force       (req_start_force),
      .req_delta_ticks       (req_delta_ticks),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_active            (rsp_active),
      .rsp_drive_force       (rsp_drive_force),
      .rsp_direction_valid   (rsp_direction_valid),
      .rsp_direction_forward (rsp_direction_forward),
      .rsp_sequence_done     (rsp_sequence_done),
      .rsp_start_rejected    (rsp_start_rejected),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < recv_stall_pct);
   end

   // Advances the shadow sequencer by one item and returns the drive result.
   function automatic frps_pkg::rsp_item_type step_sequencer(
      input frps_pkg::req_item_type item);
      frps_pkg::rsp_item_type res;
      logic [31:0]  dt;
      logic [31:0]  slew;
      logic [31:0]  target;
      logic [31:0]  gap;
      logic         finished;
      res = '0;
      finished = 1'b0;
      if (item.op == frps_pkg::OP_START) begin
         if (seq_phase != frps_pkg::PH_IDLE) begin
            res.start_rejected = 1'b1;
         end else begin
            seq_force = item.start_force;
            seq_phase = frps_pkg::PH_FWD0;
            seq_mode = frps_pkg::RM_RAMP;
            seq_aim_high = 1'b0;
            seq_hold = '0;
            seq_first_pending = 1'b1;
         end
         return res;
      end
      if (seq_phase == frps_pkg::PH_IDLE) return res;

      dt = seq_first_pending ? 32'd0 : 32'(item.delta_ticks);
      seq_first_pending = 1'b0;
      slew = (32'(cfg_slope) * dt) >> frps_pkg::SlewShift;

      case (seq_mode)
         frps_pkg::RM_RAMP: begin
            target = seq_aim_high ? 32'(cfg_high_force) : 32'(cfg_low_force);
            if (target < 32'(seq_force)) begin
               gap = 32'(seq_force) - target;
               seq_force = (slew >= gap) ? target[15:0] : seq_force - slew[15:0];
            end else if (target > 32'(seq_force)) begin
               gap = target - 32'(seq_force);
               seq_force = (slew >= gap) ? target[15:0] : seq_force + slew[15:0];
            end
            if (32'(seq_force) == target) begin
               seq_mode = frps_pkg::RM_HOLD;
               seq_hold = '0;
            end
         end
         frps_pkg::RM_HOLD: begin
            seq_hold = (seq_hold > 32'hFFFF_FFFF - dt) ? 32'hFFFF_FFFF : seq_hold + dt;
            if (seq_hold > cfg_hold_timeout) begin
               seq_mode = frps_pkg::RM_IDLE;
               finished = 1'b1;
            end
         end
         default: ;
      endcase

      if (finished) begin
         case (seq_phase)
            frps_pkg::PH_FWD0: begin
               res.direction_valid = 1'b1;
               res.direction_forward = 1'b0;
               seq_mode = frps_pkg::RM_RAMP;
               seq_phase = frps_pkg::PH_REV0;
               seq_aim_high = 1'b1;
            end
            frps_pkg::PH_REV0: begin
               seq_mode = frps_pkg::RM_RAMP;
               seq_phase = frps_pkg::PH_REV1;
               seq_aim_high = 1'b0;
            end
            frps_pkg::PH_REV1: begin
               res.direction_valid = 1'b1;
               res.direction_forward = 1'b1;
               seq_mode = frps_pkg::RM_RAMP;
               seq_phase = frps_pkg::PH_FWD1;
               seq_aim_high = 1'b1;
            end
            default: begin
               res.sequence_done = 1'b1;
               seq_phase = frps_pkg::PH_IDLE;
            end
         endcase
      end
      res.active = 1'b1;
      res.drive_force = seq_force;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      frps_pkg::rsp_item_type got;
      frps_pkg::rsp_item_type want;
      logic         moved;
      if (!reset) begin
         moved = csr_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall);
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_active, rsp_drive_force, rsp_direction_valid,
                   rsp_direction_forward, rsp_sequence_done, rsp_start_rejected};
            if (pending_drive_rsps.size() == 0) begin
               error_count++;
               $display("%0t unexpected result: expected none, actual %p", $time, got);
            end else begin
               want = pending_drive_rsps.pop_front();
               check_field("active", 16'(want.active), 16'(got.active));
               check_field("drive_force", want.drive_force, got.drive_force);
               check_field("direction_valid", 16'(want.direction_valid),
                           16'(got.direction_valid));
               check_field("direction_forward", 16'(want.direction_forward),
                           16'(got.direction_forward));
               check_field("sequence_done", 16'(want.sequence_done),
                           16'(got.sequence_done));
               check_field("start_rejected", 16'(want.start_rejected),
                           16'(got.start_rejected));
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= IdleLimit) begin
            $display("%0t watchdog: no item moved for %0d cycles", $time, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Presents one item and returns at the edge that accepts it.
   task automatic send_item(input logic op, input logic [frps_pkg::ForceWidth-1:0] level,
                            input logic [frps_pkg::TicksWidth-1:0] ticks);
      frps_pkg::req_item_type item;
      item = {op, level, ticks};
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_op = op;
      req_start_force = level;
      req_delta_ticks = ticks;
      do @(posedge clock); while (req_stall);
      pending_drive_rsps.push_back(step_sequencer(item));
      items_sent++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_drive_rsps.size() != 0) @(posedge clock);
      repeat (Latency + 2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [frps_pkg::CsrIdxWidth-1:0] idx,
                            input logic [frps_pkg::CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         frps_pkg::CSR_TARGET_HIGH:  cfg_high_force = value[15:0];
         frps_pkg::CSR_TARGET_LOW:   cfg_low_force = value[15:0];
         frps_pkg::CSR_SLOPE_RATE:   cfg_slope = value[15:0];
         default:                    cfg_hold_timeout = value;
      endcase
   endtask

   task automatic configure(input logic [31:0] high, input logic [31:0] low,
                            input logic [31:0] slope, input logic [31:0] timeout);
      wait_for_results();
      write_csr(frps_pkg::CSR_TARGET_HIGH, high);
      write_csr(frps_pkg::CSR_TARGET_LOW, low);
      write_csr(frps_pkg::CSR_SLOPE_RATE, slope);
      write_csr(frps_pkg::CSR_HOLD_TIMEOUT, timeout);
   endtask

   function automatic logic [frps_pkg::TicksWidth-1:0] random_ticks();
      case ($urandom_range(3))
         0, 1:    return 16'($urandom);
         2:       return 16'($urandom_range(0, 31));
         default: return 16'($urandom_range(0, 4095));
      endcase
   endfunction

   // Upper bits of the 16-bit registers carry noise that must be dropped.
   function automatic logic [31:0] pick_target();
      case ($urandom_range(3))
         0:       return {16'($urandom), 16'h0000};
         1:       return {16'($urandom), 16'hFFFF};
         default: return $urandom;
      endcase
   endfunction

   task automatic randomize_config();
      logic [31:0] slope;
      logic [31:0] timeout;
      case ($urandom_range(9))
         0:       slope = {16'($urandom), 16'hFFFF};
         1:       slope = {16'($urandom), 16'($urandom_range(0, 63))};
         default: slope = {16'($urandom), 16'($urandom_range(64, 65535))};
      endcase
      case ($urandom_range(9))
         0, 1:    timeout = 32'd0;
         2, 3, 4: timeout = $urandom_range(0, 100);
         9:       timeout = $urandom;
         default: timeout = $urandom_range(0, 300000);
      endcase
      configure(pick_target(), pick_target(), slope, timeout);
   endtask

   // Ticks until the sequence completes. A slow setting is replaced by a fast one
   // once the tick budget runs out, so every sequence reaches its end.
   task automatic run_to_idle();
      int unsigned ticks_left;
      logic        rushed;
      ticks_left = 200;
      rushed = 1'b0;
      while (seq_phase != frps_pkg::PH_IDLE) begin
         if (ticks_left == 0 && !rushed) begin
            rushed = 1'b1;
            configure(32'(cfg_high_force), 32'(cfg_low_force), 32'h0000_FFFF, 32'd0);
         end
         if (!rushed && $urandom_range(99) < 4) begin
            send_item(frps_pkg::OP_START, 16'($urandom), 16'($urandom));
         end
         send_item(frps_pkg::OP_TICK, 16'($urandom), rushed ? 16'hFFFF : random_ticks());
         if (ticks_left != 0) ticks_left--;
      end
   endtask

   task automatic test_full_cycle();
      configure(32'h0000_FFFF, 32'd0, 32'h0000_FFFF, 32'd0);
      send_item(frps_pkg::OP_TICK, 16'hFFFF, 16'hFFFF);   // tick while idle
      send_item(frps_pkg::OP_START, 16'hFFFF, 16'hFFFF);
      send_item(frps_pkg::OP_START, 16'h0000, 16'h0000);  // rejected while busy
      send_item(frps_pkg::OP_TICK, 16'h0000, 16'hFFFF);   // first tick counts as no time
      send_item(frps_pkg::OP_TICK, 16'h0000, 16'hFFFF);   // clamps at the low target
      send_item(frps_pkg::OP_TICK, 16'h0000, 16'h0001);   // hold ends, turn to reverse
      send_item(frps_pkg::OP_TICK, 16'h0000, 16'hFFFF);
      send_item(frps_pkg::OP_TICK, 16'h0000, 16'h0000);   // zero time does not end a zero hold
      send_item(frps_pkg::OP_TICK, 16'h0000, 16'h0005);
      send_item(frps_pkg::OP_TICK, 16'h0000, 16'hFFFF);
      send_item(frps_pkg::OP_TICK, 16'h0000, 16'h0001);   // turn to forward
      send_item(frps_pkg::OP_TICK, 16'h0000, 16'hFFFF);
      send_item(frps_pkg::OP_TICK, 16'h0000, 16'h0001);   // sequence done
      send_item(frps_pkg::OP_TICK, 16'h5555, 16'hAAAA);
      send_item(frps_pkg::OP_START, 16'h0000, 16'h0000);  // starts already at the low target
      run_to_idle();
   endtask

   task automatic test_zero_slope();
      configure(32'h0000_4000, 32'h0000_1000, 32'd0, 32'd3);
      send_item(frps_pkg::OP_START, 16'h2000, 16'h0000);
      repeat (3) send_item(frps_pkg::OP_TICK, 16'h0000, 16'hFFFF);
      configure(32'h0000_4000, 32'h0000_1000, 32'h0000_0400, 32'd3);
      send_item(frps_pkg::OP_TICK, 16'h0000, 16'h0800);
      send_item(frps_pkg::OP_TICK, 16'h0000, 16'h0800);
      send_item(frps_pkg::OP_TICK, 16'h0000, 16'h0002);
      send_item(frps_pkg::OP_TICK, 16'h0000, 16'h0002);
      run_to_idle();
   endtask

   // A hold under the largest timeout keeps growing until a lower timeout ends it.
   task automatic test_long_hold();
      configure(32'h0000_0100, 32'h0000_0100, 32'h0000_FFFF, 32'hFFFF_FFFF);
      send_item(frps_pkg::OP_START, 16'h0100, 16'h0000);
      send_item(frps_pkg::OP_TICK, 16'h0000, 16'h0000);
      repeat (24) send_item(frps_pkg::OP_TICK, 16'h0000, 16'hFFFF);
      configure(32'h0000_0100, 32'h0000_0100, 32'h0000_FFFF, 32'd1000);
      send_item(frps_pkg::OP_TICK, 16'h0000, 16'h0000);
      run_to_idle();
   endtask

   task automatic test_random_sequences(input int unsigned send_pct,
                                        input int unsigned recv_pct,
                                        input int unsigned count);
      int unsigned goal;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      goal = items_sent + count;
      while (items_sent < goal) begin
         if ($urandom_range(99) < 15) randomize_config();
         else if ($urandom_range(99) < 3) wait_for_results();
         if ($urandom_range(9) == 0) begin
            send_item(frps_pkg::OP_TICK, 16'($urandom), 16'($urandom));
         end else begin
            send_item(frps_pkg::OP_START, 16'($urandom), 16'($urandom));
            run_to_idle();
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle_pct = 22;
      recv_stall_pct = 56;
      test_full_cycle();
      test_zero_slope();
      test_random_sequences(22, 56, 430);
      test_random_sequences(56, 22, 430);
      test_random_sequences(0, 0, 430);
      test_long_hold();
      wait_for_results();
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/frps_pkg.sv
hw/rtl/frps_in_reg.sv
hw/rtl/frps_engine.sv
hw/rtl/frps_out_reg.sv
hw/rtl/force_ramp_pull_sequencer_core.sv
hw/rtl/frps_checker.sv
tb/sv/force_ramp_pull_sequencer_core_tb.sv
